/* rtl/lom_pkg.sv */
// ============================================================================
// lom_pkg: shared types and codes for the limit order matcher
// Holds the transaction structs, the command codes and the slot entry layout.
// ============================================================================
package lom_pkg;

    localparam int unsigned CmdW   = 2;
    localparam int unsigned IdW    = 24;
    localparam int unsigned StockW = 3;
    localparam int unsigned QtyW   = 20;
    localparam int unsigned PriceW = 20;

    typedef enum logic [CmdW-1:0] {
        CMD_BUY    = 2'd0,
        CMD_SELL   = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [CmdW-1:0]   cmd;
        logic [IdW-1:0]    order_id;
        logic [StockW-1:0] stock;
        logic [QtyW-1:0]   quantity;
        logic [PriceW-1:0] price;
    } in_item_t;

    typedef struct packed {
        logic [QtyW-1:0] value;
        logic            book_full;
    } out_item_t;

    // One resting order as stored in the slot memory (valid bits live apart).
    typedef struct packed {
        logic              side;
        logic [StockW-1:0] stock;
        logic [IdW-1:0]    order_id;
        logic [QtyW-1:0]   quantity;
        logic [PriceW-1:0] price;
    } slot_t;

    localparam int unsigned SlotW = $bits(slot_t);

endpackage

/* rtl/lom_ram.sv */
// ============================================================================
// lom_ram: generic single-port synchronous RAM
// One write or one read per cycle; the read data is registered.
// ============================================================================
module lom_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/limit_order_matcher.sv */
// ============================================================================
// limit_order_matcher: per-stock limit order book with price priority, ties to the lower order ID
// Resting orders sit in one slot RAM; a sequencer scans it for the best
// counter order, fills, rests remainders and tracks per-stock trade stats.
// ============================================================================
// A query goes through ST_QUERY. A cancel scans every slot, then ST_DECIDE clears
// the match. A buy or sell with a bad stock or zero quantity leaves the scan for
// ST_DONE at once. Other buys and sells scan once per fill, then pass ST_DECIDE,
// ST_FRD and ST_FILL, and end in ST_REST, or in ST_DONE once a fill uses up the quantity.
// One transaction at a time: the next is taken once the result has left.
// Reset clears the valid bits and the per-stock statistics; RAM is not cleared.
module limit_order_matcher #(
    parameter int unsigned STOCKS      = 6,
    parameter int unsigned ORDER_SLOTS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lom_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lom_pkg::out_item_t out_data
);

    localparam int unsigned AW = $clog2(ORDER_SLOTS);
    localparam int unsigned SW = (STOCKS > 1) ? $clog2(STOCKS) : 1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SCAN   = 8'b0000_0010,
        ST_DECIDE = 8'b0000_0100,
        ST_FRD    = 8'b0000_1000,
        ST_FILL   = 8'b0001_0000,
        ST_REST   = 8'b0010_0000,
        ST_QUERY  = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    lom_pkg::in_item_t  req_reg, req_next;
    logic [lom_pkg::QtyW-1:0] qty_reg, qty_next;
    logic [AW:0] idx_reg, idx_next;          // scan address, one past the end
    logic        rd_vld_reg, rd_vld_next;    // RAM data is for slot rd_idx_reg
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic        best_vld_reg, best_vld_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    logic [lom_pkg::PriceW-1:0] best_price_reg, best_price_next;
    logic [lom_pkg::IdW-1:0] best_id_reg, best_id_next;
    logic        free_vld_reg, free_vld_next;
    logic [AW-1:0] free_idx_reg, free_idx_next;
    logic [ORDER_SLOTS-1:0] valid_reg, valid_next;
    logic [STOCKS-1:0] has_trade_reg, has_trade_next;
    logic [lom_pkg::PriceW-1:0] min_reg [STOCKS];
    logic [lom_pkg::PriceW-1:0] min_next [STOCKS];
    logic [lom_pkg::QtyW-1:0] prof_reg [STOCKS];
    logic [lom_pkg::QtyW-1:0] prof_next [STOCKS];
    logic        out_valid_reg, out_valid_next;
    lom_pkg::out_item_t out_reg, out_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    lom_pkg::slot_t ram_wdata, ram_rdata;

    lom_ram #(
        .WIDTH(lom_pkg::SlotW),
        .DEPTH(ORDER_SLOTS)
    ) u_slots (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    logic stock_ok;
    logic [SW-1:0] sidx;
    logic is_order;
    logic crosses;
    logic better;
    logic match;
    logic [lom_pkg::PriceW-1:0] trade_p;
    logic [lom_pkg::PriceW-1:0] new_min;
    logic [lom_pkg::PriceW-1:0] gain;

    always_comb
    begin
        stock_ok = (32'(req_reg.stock) < STOCKS);
        sidx     = SW'(req_reg.stock);
        is_order = (req_reg.cmd == lom_pkg::CMD_BUY) || (req_reg.cmd == lom_pkg::CMD_SELL);
        crosses  = req_reg.cmd[0] ? (ram_rdata.price >= req_reg.price)
                                  : (ram_rdata.price <= req_reg.price);
        if (ram_rdata.price != best_price_reg)
        begin
            better = req_reg.cmd[0] ? (ram_rdata.price > best_price_reg)
                                    : (ram_rdata.price < best_price_reg);
        end
        else
        begin
            better = ram_rdata.order_id < best_id_reg;
        end
        match = valid_reg[rd_idx_reg] && (ram_rdata.stock == req_reg.stock)
                && (ram_rdata.side == !req_reg.cmd[0]) && crosses;
        trade_p = best_price_reg;
        new_min = (!has_trade_reg[sidx] || (trade_p < min_reg[sidx])) ? trade_p
                                                                        : min_reg[sidx];
        gain = trade_p - new_min;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        qty_next       = qty_reg;
        idx_next       = idx_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_price_next = best_price_reg;
        best_id_next   = best_id_reg;
        free_vld_next  = free_vld_reg;
        free_idx_next  = free_idx_reg;
        valid_next     = valid_reg;
        has_trade_next = has_trade_reg;
        min_next       = min_reg;
        prof_next      = prof_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_addr       = idx_reg[AW-1:0];
        ram_wdata      = ram_rdata;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    req_next      = in_data;
                    qty_next      = in_data.quantity;
                    idx_next      = '0;
                    best_vld_next = 1'b0;
                    free_vld_next = 1'b0;
                    if (in_data.cmd == lom_pkg::CMD_QUERY)
                    begin
                        state_next = ST_QUERY;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue one read per cycle and judge the slot read last cycle.
                if (idx_reg < (AW+1)'(ORDER_SLOTS))
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg[AW-1:0];
                    idx_next    = idx_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (!valid_reg[rd_idx_reg] && !free_vld_reg)
                    begin
                        free_vld_next = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                    if (req_reg.cmd == lom_pkg::CMD_CANCEL)
                    begin
                        if (valid_reg[rd_idx_reg] && (ram_rdata.order_id == req_reg.order_id)
                            && !best_vld_reg)
                        begin
                            best_vld_next = 1'b1;
                            best_idx_next = rd_idx_reg;
                        end
                    end
                    else if (match && (!best_vld_reg || better))
                    begin
                        best_vld_next   = 1'b1;
                        best_idx_next   = rd_idx_reg;
                        best_price_next = ram_rdata.price;
                        best_id_next    = ram_rdata.order_id;
                    end
                end
                if (!rd_vld_reg && (idx_reg == (AW+1)'(ORDER_SLOTS)))
                begin
                    state_next = ST_DECIDE;
                end
                if (is_order && (!stock_ok || (qty_reg == '0)))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DECIDE:
            begin
                if (req_reg.cmd == lom_pkg::CMD_CANCEL)
                begin
                    qty_next = '0;
                    if (best_vld_reg)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                        qty_next = lom_pkg::QtyW'(1);
                    end
                    state_next = ST_DONE;
                end
                else if (best_vld_reg)
                begin
                    ram_addr   = best_idx_reg;
                    state_next = ST_FRD;
                end
                else
                begin
                    state_next = ST_REST;
                end
            end
            ST_FRD:
            begin
                ram_addr   = best_idx_reg;
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                // ram_rdata holds the best resting order.
                has_trade_next[sidx] = 1'b1;
                min_next[sidx] = new_min;
                if (gain > prof_reg[sidx])
                begin
                    prof_next[sidx] = gain;
                end
                ram_addr = best_idx_reg;
                if (qty_reg >= ram_rdata.quantity)
                begin
                    qty_next = qty_reg - ram_rdata.quantity;
                    valid_next[best_idx_reg] = 1'b0;
                end
                else
                begin
                    ram_we             = 1'b1;
                    ram_wdata.quantity = ram_rdata.quantity - qty_reg;
                    qty_next           = '0;
                end
                idx_next      = '0;
                best_vld_next = 1'b0;
                free_vld_next = 1'b0;
                state_next    = ST_SCAN;
            end
            ST_REST:
            begin
                if (qty_reg != '0)
                begin
                    if (free_vld_reg)
                    begin
                        ram_we             = 1'b1;
                        ram_addr           = free_idx_reg;
                        ram_wdata.side     = req_reg.cmd[0];
                        ram_wdata.stock    = req_reg.stock;
                        ram_wdata.order_id = req_reg.order_id;
                        ram_wdata.quantity = qty_reg;
                        ram_wdata.price    = req_reg.price;
                        valid_next[free_idx_reg] = 1'b1;
                    end
                    else
                    begin
                        out_next.book_full = 1'b1;
                    end
                end
                out_next.value = qty_reg;
                if (!free_vld_reg && (qty_reg != '0))
                begin
                    out_next.book_full = 1'b1;
                end
                else
                begin
                    out_next.book_full = 1'b0;
                end
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_QUERY:
            begin
                out_next.value     = (stock_ok && has_trade_reg[sidx]) ? prof_reg[sidx] : '0;
                out_next.book_full = 1'b0;
                out_valid_next     = 1'b1;
                state_next         = ST_IDLE;
            end
            ST_DONE:
            begin
                out_next.value     = qty_reg;
                out_next.book_full = 1'b0;
                out_valid_next     = 1'b1;
                state_next         = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_vld_reg    <= 1'b0;
            valid_reg     <= '0;
            has_trade_reg <= '0;
            out_valid_reg <= 1'b0;
            best_vld_reg  <= 1'b0;
            free_vld_reg  <= 1'b0;
            for (int i = 0; i < STOCKS; i++)
            begin
                min_reg[i]  <= '0;
                prof_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            valid_reg     <= valid_next;
            has_trade_reg <= has_trade_next;
            out_valid_reg <= out_valid_next;
            best_vld_reg  <= best_vld_next;
            free_vld_reg  <= free_vld_next;
            min_reg       <= min_next;
            prof_reg      <= prof_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        qty_reg        <= qty_next;
        idx_reg        <= idx_next;
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_price_reg <= best_price_next;
        best_id_reg    <= best_id_next;
        free_idx_reg   <= free_idx_next;
        out_reg        <= out_next;
    end

    // A new transaction is never taken while a result is still pending.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !out_valid_reg)
        else $error("input accepted while result pending");

    // A result appears only on leaving a finishing state.
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_REST || state_reg == ST_QUERY
                                        || state_reg == ST_DONE))
        else $error("result raised from wrong state");

    // Book full is only flagged for a buy or sell.
    a_full_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.book_full) |-> (req_reg.cmd[1] == 1'b0))
        else $error("book full on non-order command");

    // The RAM is written only while filling or resting.
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_FILL || state_reg == ST_REST))
        else $error("unexpected slot write");

endmodule
